### rtl/bopg_pkg.sv
`default_nettype none

package bopg_pkg;

  typedef enum logic [1:0] {
    CMD_PERSON = 2'd0,
    CMD_CAMERA = 2'd1,
    CMD_EOF    = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AREA,
    S_SCALE,
    S_MULT,
    S_TEST
  } state_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_RATIO      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_TO_ACTIVATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS         = 2'd2;

  localparam int RATIO_W    = 9;
  localparam int FRAMES_W   = 8;
  localparam int TICKS_W    = 16;
  localparam int RATIO_FRAC = 8;

  localparam logic [RATIO_W-1:0]  RATIO_RST  = 9'd179;
  localparam logic [FRAMES_W-1:0] FRAMES_RST = 8'd5;
  localparam logic [TICKS_W-1:0]  HOLD_RST   = 16'd5;

  localparam logic [FRAMES_W-1:0] FRAMES_MAX = 8'hFF;
  localparam logic [TICKS_W-1:0]  TICKS_MAX  = 16'hFFFF;

  typedef struct packed {
    logic                dark_out;
    logic                frame_matched;
    logic [FRAMES_W-1:0] frames_counted;
    logic                table_overflow;
  } result_t;

endpackage

`default_nettype wire

### rtl/bopg_if.sv
`default_nettype none

interface bopg_in_if #(
  parameter int COORD_BITS = 12
);
  import bopg_pkg::*;

  logic                  valid;
  logic                  ready;
  cmd_t                  cmd;
  logic [COORD_BITS-1:0] left_x;
  logic [COORD_BITS-1:0] top_y;
  logic [COORD_BITS-1:0] right_x;
  logic [COORD_BITS-1:0] bottom_y;

  modport source (output valid, cmd, left_x, top_y, right_x, bottom_y, input ready);
  modport sink   (input valid, cmd, left_x, top_y, right_x, bottom_y, output ready);
endinterface

interface bopg_out_if;
  import bopg_pkg::*;

  logic                valid;
  logic                ready;
  logic                dark_out;
  logic                frame_matched;
  logic [FRAMES_W-1:0] frames_counted;
  logic                table_overflow;

  modport source (output valid, dark_out, frame_matched, frames_counted, table_overflow,
                  input ready);
  modport sink   (input valid, dark_out, frame_matched, frames_counted, table_overflow,
                  output ready);
endinterface

interface bopg_cfg_if;
  import bopg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

### rtl/box_overlap_persistence_gate.sv
// Person and tick beats are taken when idle; so is end-of-frame unless an untaken result is held.
// Camera box: area, ratio scaling, then multiply and test per stored person box; an inverted box
// ends after area; zero area, empty table or prior match end after scaling; one shared multiplier.
// End-of-frame result appears on out_ch the cycle after the beat, held until taken.
// Synchronous active-low reset clears control state and loads config defaults
// (ratio 179, frames 5, hold 5); the person table is not cleared.
`default_nettype none

module box_overlap_persistence_gate #(
  parameter int PERSON_DEPTH = 16,
  parameter int COORD_BITS   = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bopg_in_if.sink   in_ch,
  bopg_out_if.source out_ch,
  bopg_cfg_if.sink  cfg_ch
);
  import bopg_pkg::*;

  localparam int IDX_W  = (PERSON_DEPTH > 1) ? $clog2(PERSON_DEPTH) : 1;
  localparam int FILL_W = $clog2(PERSON_DEPTH + 1);
  localparam int BOX_W  = 4 * COORD_BITS;
  localparam int AREA_W = 2 * COORD_BITS;
  localparam int MB_W   = (COORD_BITS > RATIO_W) ? COORD_BITS : RATIO_W;
  localparam int PROD_W = AREA_W + MB_W;

  state_t state_r, state_nxt;

  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                overflow_r, overflow_nxt;
  logic                match_seen_r, match_seen_nxt;
  logic                last_match_r, last_match_nxt;
  logic [FRAMES_W-1:0] run_r, run_nxt;
  logic                dark_r, dark_nxt;
  logic [TICKS_W-1:0]  ticks_r, ticks_nxt;
  logic [RATIO_W-1:0]  ratio_r, ratio_nxt;
  logic [FRAMES_W-1:0] fta_r, fta_nxt;
  logic [TICKS_W-1:0]  hold_r, hold_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [BOX_W-1:0]    cam_r, cam_nxt;
  logic [FILL_W-1:0]   cnt_r, cnt_nxt;
  logic [AREA_W-1:0]   area_r, area_nxt;
  logic [PROD_W-1:0]   need_r, need_nxt;
  logic [AREA_W-1:0]   inter_r, inter_nxt;
  logic                ov_ok_r, ov_ok_nxt;
  result_t             res_r, res_nxt;
  logic [BOX_W-1:0]    rd_data_r;

  logic [BOX_W-1:0]    table_mem [PERSON_DEPTH];

  logic                in_acc, cfg_acc;
  logic [BOX_W-1:0]    in_box;
  logic                tbl_wr;
  logic [IDX_W-1:0]    rd_addr;

  logic [COORD_BITS-1:0] cam_x1, cam_y1, cam_x2, cam_y2;
  logic [COORD_BITS-1:0] per_x1, per_y1, per_x2, per_y2;
  logic [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                  cam_inv, ov_ok, hit;
  logic [AREA_W-1:0]     mul_a;
  logic [MB_W-1:0]       mul_b;
  logic [PROD_W-1:0]     prod;

  // frame-end bookkeeping
  logic [FRAMES_W-1:0] eof_run;
  logic                eof_dark;
  logic [TICKS_W-1:0]  eof_ticks;

  // handshakes
  assign in_ch.ready = (state_r == S_IDLE) &&
                       (!out_valid_r || out_ch.ready || in_ch.cmd != CMD_EOF);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc     = cfg_ch.valid;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.dark_out       = res_r.dark_out;
  assign out_ch.frame_matched  = res_r.frame_matched;
  assign out_ch.frames_counted = res_r.frames_counted;
  assign out_ch.table_overflow = res_r.table_overflow;

  assign in_box = {in_ch.left_x, in_ch.top_y, in_ch.right_x, in_ch.bottom_y};

  assign cam_x1 = cam_r[4*COORD_BITS-1 -: COORD_BITS];
  assign cam_y1 = cam_r[3*COORD_BITS-1 -: COORD_BITS];
  assign cam_x2 = cam_r[2*COORD_BITS-1 -: COORD_BITS];
  assign cam_y2 = cam_r[COORD_BITS-1 -: COORD_BITS];
  assign per_x1 = rd_data_r[4*COORD_BITS-1 -: COORD_BITS];
  assign per_y1 = rd_data_r[3*COORD_BITS-1 -: COORD_BITS];
  assign per_x2 = rd_data_r[2*COORD_BITS-1 -: COORD_BITS];
  assign per_y2 = rd_data_r[COORD_BITS-1 -: COORD_BITS];

  assign cam_inv = (cam_x2 < cam_x1) || (cam_y2 < cam_y1);

  assign lo_x  = (cam_x1 > per_x1) ? cam_x1 : per_x1;
  assign hi_x  = (cam_x2 < per_x2) ? cam_x2 : per_x2;
  assign lo_y  = (cam_y1 > per_y1) ? cam_y1 : per_y1;
  assign hi_y  = (cam_y2 < per_y2) ? cam_y2 : per_y2;
  assign ov_ok = (hi_x >= lo_x) && (hi_y >= lo_y);

  // shared multiplier
  always_comb begin
    case (state_r)
      S_AREA: begin
        mul_a = AREA_W'(COORD_BITS'(cam_x2 - cam_x1));
        mul_b = MB_W'(COORD_BITS'(cam_y2 - cam_y1));
      end
      S_SCALE: begin
        mul_a = area_r;
        mul_b = MB_W'(ratio_r);
      end
      S_MULT: begin
        mul_a = AREA_W'(COORD_BITS'(hi_x - lo_x));
        mul_b = MB_W'(COORD_BITS'(hi_y - lo_y));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign hit = ov_ok_r && (PROD_W'({inter_r, {RATIO_FRAC{1'b0}}}) >= need_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.cmd == CMD_CAMERA) state_nxt = S_AREA;
      end
      S_AREA: begin
        state_nxt = cam_inv ? S_IDLE : S_SCALE;
      end
      S_SCALE: begin
        if (area_r == '0 || fill_r == '0 || match_seen_r) state_nxt = S_IDLE;
        else state_nxt = S_MULT;
      end
      S_MULT: begin
        state_nxt = S_TEST;
      end
      S_TEST: begin
        state_nxt = (FILL_W'(cnt_r + 1'b1) < fill_r) ? S_MULT : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // frame-end activation rule
  always_comb begin
    eof_run   = run_r;
    eof_dark  = dark_r;
    eof_ticks = ticks_r;
    if (!last_match_r) begin
      eof_run = '0;
      if (ticks_r >= hold_r) eof_dark = 1'b0;
    end
    if (last_match_r && run_r >= fta_r) begin
      eof_dark  = 1'b1;
      eof_run   = '0;
      eof_ticks = '0;
    end
    if (match_seen_r && eof_run != FRAMES_MAX) eof_run = FRAMES_W'(eof_run + 1'b1);
  end

  // datapath and bookkeeping
  always_comb begin
    fill_nxt       = fill_r;
    overflow_nxt   = overflow_r;
    match_seen_nxt = match_seen_r;
    last_match_nxt = last_match_r;
    run_nxt        = run_r;
    dark_nxt       = dark_r;
    ticks_nxt      = ticks_r;
    ratio_nxt      = ratio_r;
    fta_nxt        = fta_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    cam_nxt        = cam_r;
    cnt_nxt        = cnt_r;
    area_nxt       = area_r;
    need_nxt       = need_r;
    inter_nxt      = inter_r;
    ov_ok_nxt      = ov_ok_r;
    res_nxt        = res_r;
    tbl_wr         = 1'b0;

    if (cfg_acc) begin
      case (cfg_ch.idx)
        CFG_OVERLAP_RATIO:      ratio_nxt = cfg_ch.data[RATIO_W-1:0];
        CFG_FRAMES_TO_ACTIVATE: fta_nxt   = cfg_ch.data[FRAMES_W-1:0];
        CFG_HOLD_TICKS:         hold_nxt  = cfg_ch.data[TICKS_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.cmd)
            CMD_PERSON: begin
              if (fill_r < FILL_W'(PERSON_DEPTH)) begin
                tbl_wr   = 1'b1;
                fill_nxt = FILL_W'(fill_r + 1'b1);
              end else begin
                overflow_nxt = 1'b1;
              end
            end
            CMD_CAMERA: begin
              cam_nxt = in_box;
            end
            CMD_TICK: begin
              if (ticks_r != TICKS_MAX) ticks_nxt = TICKS_W'(ticks_r + 1'b1);
            end
            CMD_EOF: begin
              run_nxt        = eof_run;
              dark_nxt       = eof_dark;
              ticks_nxt      = eof_ticks;
              last_match_nxt = match_seen_r;
              res_nxt.dark_out       = eof_dark;
              res_nxt.frame_matched  = match_seen_r;
              res_nxt.frames_counted = eof_run;
              res_nxt.table_overflow = overflow_r;
              out_valid_nxt  = 1'b1;
              fill_nxt       = '0;
              overflow_nxt   = 1'b0;
              match_seen_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_AREA: begin
        area_nxt = prod[AREA_W-1:0];
      end
      S_SCALE: begin
        need_nxt = prod;
        cnt_nxt  = '0;
      end
      S_MULT: begin
        inter_nxt = prod[AREA_W-1:0];
        ov_ok_nxt = ov_ok;
      end
      S_TEST: begin
        if (hit) match_seen_nxt = 1'b1;
        cnt_nxt = FILL_W'(cnt_r + 1'b1);
      end
      default: ;
    endcase
  end

  assign rd_addr = cnt_nxt[IDX_W-1:0];

  // person table
  always_ff @(posedge clk) begin
    if (tbl_wr) table_mem[fill_r[IDX_W-1:0]] <= in_box;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      overflow_r   <= 1'b0;
      match_seen_r <= 1'b0;
      last_match_r <= 1'b0;
      run_r        <= '0;
      dark_r       <= 1'b0;
      ticks_r      <= '0;
      ratio_r      <= RATIO_RST;
      fta_r        <= FRAMES_RST;
      hold_r       <= HOLD_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      overflow_r   <= overflow_nxt;
      match_seen_r <= match_seen_nxt;
      last_match_r <= last_match_nxt;
      run_r        <= run_nxt;
      dark_r       <= dark_nxt;
      ticks_r      <= ticks_nxt;
      ratio_r      <= ratio_nxt;
      fta_r        <= fta_nxt;
      hold_r       <= hold_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cam_r   <= cam_nxt;
    cnt_r   <= cnt_nxt;
    area_r  <= area_nxt;
    need_r  <= need_nxt;
    inter_r <= inter_nxt;
    ov_ok_r <= ov_ok_nxt;
    res_r   <= res_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(PERSON_DEPTH))
    else $error("person fill count exceeds table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MULT || state_r == S_TEST) |-> cnt_r < fill_r)
    else $error("table scan past filled entries");

  a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == CMD_EOF) |=> out_valid_r)
    else $error("end-of-frame beat gave no result");

  a_dark_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dark_r) |-> ticks_r == '0)
    else $error("dark asserted without trigger restarting the hold timer");

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bopg_pkg::*;

  localparam int COORD_W = 12;
  localparam int DEPTH = 16;
  localparam int unsigned COORD_MAX = 4095;
  localparam int unsigned PHASE_BEATS = 115;
  // settle wait covers a camera box scanned against a full table
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned END_LIMIT = 40000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
  } rect_t;

  typedef struct packed {
    cmd_t  cmd;
    rect_t box;
  } box_beat_t;

  logic clk;
  logic rst_n;

  bopg_in_if #(.COORD_BITS(COORD_W)) in_ch ();
  bopg_out_if out_ch ();
  bopg_cfg_if cfg_ch ();

  box_overlap_persistence_gate #(
    .PERSON_DEPTH(DEPTH),
    .COORD_BITS(COORD_W)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // gate model state
  rect_t                people[DEPTH];
  int unsigned          people_fill;
  bit                   drop_flag;
  bit                   hit_flag;
  bit                   prev_hit;
  bit                   dark_lvl;
  logic [FRAMES_W-1:0]  run_len;
  logic [TICKS_W-1:0]   tick_age;
  logic [RATIO_W-1:0]   ratio_q8;
  logic [FRAMES_W-1:0]  frames_need;
  logic [TICKS_W-1:0]   hold_need;

  box_beat_t   beats_pending[$];
  result_t     reports_due[$];
  box_beat_t   beat_now;
  int unsigned send_wait;
  int unsigned take_wait;
  bit          send_calm;
  bit          take_calm;
  bit          streak_hot;

  int unsigned beats_queued;
  int unsigned beats_accepted;
  int unsigned reports_checked;
  int unsigned matched_reports;
  int unsigned dark_reports;
  int unsigned overflow_reports;
  int unsigned reg_writes;
  int unsigned fault_count;

  always #10 clk = ~clk;

  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic bit covers(rect_t cam, rect_t per);
    logic [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [63:0] area, overlap;
    if (cam.x2 < cam.x1 || cam.y2 < cam.y1) return 1'b0;
    area = 64'(cam.x2 - cam.x1) * 64'(cam.y2 - cam.y1);
    if (area == 0) return 1'b0;
    lo_x = (cam.x1 > per.x1) ? cam.x1 : per.x1;
    hi_x = (cam.x2 < per.x2) ? cam.x2 : per.x2;
    lo_y = (cam.y1 > per.y1) ? cam.y1 : per.y1;
    hi_y = (cam.y2 < per.y2) ? cam.y2 : per.y2;
    if (hi_x < lo_x || hi_y < lo_y) return 1'b0;
    overlap = 64'(hi_x - lo_x) * 64'(hi_y - lo_y);
    return (overlap * 64'd256) >= (64'(ratio_q8) * area);
  endfunction

  task automatic predict_gate(input box_beat_t b);
    result_t rep;
    case (b.cmd)
      CMD_PERSON: begin
        if (people_fill < DEPTH) begin
          people[people_fill] = b.box;
          people_fill++;
        end else begin
          drop_flag = 1'b1;
        end
      end
      CMD_CAMERA: begin
        for (int i = 0; i < people_fill; i++)
          if (covers(b.box, people[i])) hit_flag = 1'b1;
      end
      CMD_TICK: begin
        if (tick_age != TICKS_MAX) tick_age++;
      end
      CMD_EOF: begin
        // activation rule runs on the previous frame's verdict
        if (!prev_hit) begin
          run_len = '0;
          if (tick_age >= hold_need) dark_lvl = 1'b0;
        end
        if (prev_hit && run_len >= frames_need) begin
          dark_lvl = 1'b1;
          run_len = '0;
          tick_age = '0;
        end
        prev_hit = hit_flag;
        if (hit_flag && run_len != FRAMES_MAX) run_len++;
        rep.dark_out = dark_lvl;
        rep.frame_matched = hit_flag;
        rep.frames_counted = run_len;
        rep.table_overflow = drop_flag;
        reports_due.push_back(rep);
        people_fill = 0;
        drop_flag = 1'b0;
        hit_flag = 1'b0;
      end
    endcase
  endtask

  task automatic check_report();
    result_t want;
    if (reports_due.size() == 0) begin
      $error("frame report arrived with none pending");
      fault_count++;
    end else begin
      want = reports_due.pop_front();
      if (out_ch.dark_out !== want.dark_out) begin
        $error("dark_out: expected %0d, got %0d", want.dark_out, out_ch.dark_out);
        fault_count++;
      end
      if (out_ch.frame_matched !== want.frame_matched) begin
        $error("frame_matched: expected %0d, got %0d", want.frame_matched,
               out_ch.frame_matched);
        fault_count++;
      end
      if (out_ch.frames_counted !== want.frames_counted) begin
        $error("frames_counted: expected %0d, got %0d", want.frames_counted,
               out_ch.frames_counted);
        fault_count++;
      end
      if (out_ch.table_overflow !== want.table_overflow) begin
        $error("table_overflow: expected %0d, got %0d", want.table_overflow,
               out_ch.table_overflow);
        fault_count++;
      end
      reports_checked++;
      if (want.frame_matched) matched_reports++;
      if (want.dark_out) dark_reports++;
      if (want.table_overflow) overflow_reports++;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_gate(beat_now);
        beats_accepted++;
        send_wait = draw_wait(send_calm);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_wait != 0) begin
          send_wait--;
          in_ch.valid <= 1'b0;
        end else if (beats_pending.size() != 0) begin
          beat_now = beats_pending.pop_front();
          in_ch.cmd <= beat_now.cmd;
          in_ch.left_x <= beat_now.box.x1;
          in_ch.top_y <= beat_now.box.y1;
          in_ch.right_x <= beat_now.box.x2;
          in_ch.bottom_y <= beat_now.box.y2;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, may stall after each beat it takes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_report();
        take_wait = draw_wait(take_calm);
      end
      if (take_wait != 0) begin
        take_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic rect_t rand_rect();
    rect_t r;
    r.x1 = $urandom_range(0, COORD_MAX);
    r.y1 = $urandom_range(0, COORD_MAX);
    r.x2 = $urandom_range(0, COORD_MAX);
    r.y2 = $urandom_range(0, COORD_MAX);
    return r;
  endfunction

  function automatic rect_t rand_person();
    rect_t r;
    if ($urandom_range(0, 7) == 0) return rand_rect();
    r.x1 = $urandom_range(0, COORD_MAX - 100);
    r.y1 = $urandom_range(0, COORD_MAX - 100);
    r.x2 = r.x1 + $urandom_range(1, 100);
    r.y2 = r.y1 + $urandom_range(1, 100);
    return r;
  endfunction

  function automatic bit has_area(rect_t r);
    return r.x2 > r.x1 && r.y2 > r.y1;
  endfunction

  // camera box mostly inside the person box, sometimes spilling past it
  function automatic rect_t cam_near(rect_t p);
    rect_t c;
    int unsigned spill;
    c.x1 = p.x1 + $urandom_range(0, (p.x2 - p.x1) / 2);
    c.y1 = p.y1 + $urandom_range(0, (p.y2 - p.y1) / 2);
    c.x2 = c.x1 + $urandom_range(1, p.x2 - c.x1);
    c.y2 = c.y1 + $urandom_range(1, p.y2 - c.y1);
    if ($urandom_range(0, 2) == 0) begin
      spill = $urandom_range(0, 24);
      c.x2 = (c.x2 + spill > COORD_MAX) ? COORD_MAX : c.x2 + spill;
    end
    if ($urandom_range(0, 3) == 0) begin
      spill = $urandom_range(0, 24);
      c.y1 = (c.y1 < spill) ? 0 : c.y1 - spill;
    end
    return c;
  endfunction

  task automatic push_rect(input cmd_t c, input rect_t r);
    box_beat_t b;
    b.cmd = c;
    b.box = r;
    beats_pending.push_back(b);
    beats_queued++;
  endtask

  task automatic push_box(input cmd_t c, input int unsigned lx, ty, rx, by);
    rect_t r;
    r.x1 = lx;
    r.y1 = ty;
    r.x2 = rx;
    r.y2 = by;
    push_rect(c, r);
  endtask

  task automatic queue_frame(input bit hot);
    rect_t kept[$];
    rect_t r;
    int unsigned n_people, n_cams;
    n_people = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 4);
    if (hot && n_people == 0) n_people = 1;
    for (int i = 0; i < n_people; i++) begin
      r = rand_person();
      if (hot && i == 0 && !has_area(r)) r = '{12'd10, 12'd10, 12'd90, 12'd60};
      push_rect(CMD_PERSON, r);
      if (i < DEPTH && has_area(r)) kept.push_back(r);
      if ($urandom_range(0, 9) == 0) push_rect(CMD_TICK, rand_rect());
    end
    n_cams = $urandom_range(0, 3);
    for (int i = 0; i < n_cams; i++) begin
      if (kept.size() != 0 &&
          (hot ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 5) == 0)))
        push_rect(CMD_CAMERA, cam_near(kept[$urandom_range(0, kept.size() - 1)]));
      else
        push_rect(CMD_CAMERA, rand_rect());
    end
    if (hot && kept.size() != 0)
      push_rect(CMD_CAMERA, cam_near(kept[$urandom_range(0, kept.size() - 1)]));
    // person box arriving after the cameras
    if ($urandom_range(0, 4) == 0) begin
      r = rand_person();
      push_rect(CMD_PERSON, r);
      if (has_area(r)) push_rect(CMD_CAMERA, cam_near(r));
    end
    repeat ($urandom_range(0, 3)) push_rect(CMD_TICK, rand_rect());
    push_rect(CMD_EOF, rand_rect());
  endtask

  task automatic run_phase(input int unsigned n_beats);
    int unsigned start;
    start = beats_queued;
    while (beats_queued - start < n_beats) begin
      if ($urandom_range(0, 5) == 0) streak_hot = !streak_hot;
      queue_frame(streak_hot);
    end
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic drain();
    int unsigned waited;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((beats_pending.size() != 0 || in_ch.valid || reports_due.size() != 0) &&
               waited < END_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.idx <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_OVERLAP_RATIO:      ratio_q8 = val[RATIO_W-1:0];
      CFG_FRAMES_TO_ACTIVATE: frames_need = val[FRAMES_W-1:0];
      CFG_HOLD_TICKS:         hold_need = val[TICKS_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input int unsigned ratio, frames, hold, input bit poke_spare);
    @(posedge clk);
    write_reg(CFG_OVERLAP_RATIO, CFG_DATA_W'(ratio));
    write_reg(CFG_FRAMES_TO_ACTIVATE, CFG_DATA_W'(frames));
    write_reg(CFG_HOLD_TICKS, CFG_DATA_W'(hold));
    if (poke_spare) write_reg(CFG_SPARE_IDX, {CFG_DATA_W{1'b1}});
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TICK;
    in_ch.left_x = '0;
    in_ch.top_y = '0;
    in_ch.right_x = '0;
    in_ch.bottom_y = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = CFG_OVERLAP_RATIO;
    cfg_ch.data = '0;

    people_fill = 0;
    drop_flag = 1'b0;
    hit_flag = 1'b0;
    prev_hit = 1'b0;
    dark_lvl = 1'b0;
    run_len = '0;
    tick_age = '0;
    ratio_q8 = RATIO_RST;
    frames_need = FRAMES_RST;
    hold_need = HOLD_RST;
    send_calm = 1'b0;
    take_calm = 1'b0;
    streak_hot = 1'b1;
    beats_queued = 0;
    beats_accepted = 0;
    reports_checked = 0;
    matched_reports = 0;
    dark_reports = 0;
    overflow_reports = 0;
    reg_writes = 0;
    fault_count = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // full-frame person, plain match, every command
    push_box(CMD_PERSON, 0, 0, COORD_MAX, COORD_MAX);
    push_box(CMD_CAMERA, 100, 100, 200, 200);
    push_box(CMD_TICK, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push_box(CMD_EOF, 0, 0, 0, 0);
    // inverted person, touching edge, zero-area and inverted cameras
    push_box(CMD_PERSON, 300, 300, 100, 100);
    push_box(CMD_PERSON, 0, 0, 100, 100);
    push_box(CMD_CAMERA, 100, 0, 200, 100);
    push_box(CMD_CAMERA, 5, 5, 5, 50);
    push_box(CMD_CAMERA, 200, 100, 100, 200);
    push_box(CMD_CAMERA, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push_box(CMD_EOF, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    // late persons; 176/256 misses at 179, 192/256 hits
    push_box(CMD_CAMERA, 0, 0, 16, 16);
    push_box(CMD_PERSON, 0, 0, 16, 11);
    push_box(CMD_CAMERA, 0, 0, 16, 16);
    push_box(CMD_PERSON, 0, 0, 16, 12);
    push_box(CMD_CAMERA, 0, 0, 16, 16);
    push_box(CMD_EOF, 0, 0, 0, 0);
    push_box(CMD_TICK, 0, 0, 0, 0);
    push_box(CMD_TICK, 0, 0, 0, 0);
    push_box(CMD_EOF, 0, 0, 0, 0);
    drain();

    set_config(179, 3, 4, 1'b0);
    run_phase(PHASE_BEATS);
    drain();
    set_config(0, 0, 0, 1'b1);
    run_phase(PHASE_BEATS);
    drain();
    set_config(256, 1, 65535, 1'b0);
    run_phase(PHASE_BEATS);
    drain();
    set_config(511, 255, 7, 1'b0);
    run_phase(PHASE_BEATS);
    drain();
    set_config(1, 2, 2, 1'b0);
    run_phase(PHASE_BEATS);
    drain();
    set_config($urandom_range(100, 256), $urandom_range(1, 6), $urandom_range(0, 20), 1'b0);
    run_phase(PHASE_BEATS);
    drain();

    if (reports_due.size() != 0) begin
      $error("%0d frame reports never arrived", reports_due.size());
      fault_count++;
    end
    $display("ran %0d beats over 7 register settings (%0d register writes)",
             beats_accepted, reg_writes);
    $display("checked %0d frame reports: %0d matched, %0d dark, %0d with dropped persons",
             reports_checked, matched_reports, dark_reports, overflow_reports);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule
